/* hw/rtl/mlt_pkg.sv */
// ----------------------------------------------------------------------------
// mlt_pkg
// shared constants and types of the mac learning table
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned PortBitsDef     = 4;

  localparam int unsigned MacW   = 48;
  localparam int unsigned AgeW   = 16;
  localparam int unsigned OpW    = 2;
  localparam int unsigned PortW  = 4;
  localparam int unsigned CountW = 7;

  localparam logic [AgeW-1:0]   AgeTimeoutRst = 16'd30;
  localparam logic [AgeW-1:0]   AgeMax        = 16'hFFFF;
  localparam logic [CountW-1:0] CountMax      = 7'd127;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_LEARN  = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

/* hw/rtl/mlt_ram.sv */
// ----------------------------------------------------------------------------
// mlt_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module mlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mac_learning_table_with_aging.sv */
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging
// fully associative mac-to-port learning table with one-second aging
// ----------------------------------------------------------------------------
// usage
//   a request is taken when start_i is high and busy_o is low; operation_i
//   selects lookup, learn or one-second tick, mac_address_i and port_in_i
//   carry the payload. every request gives exactly one result, shown on
//   hit_o, port_out_o, table_full_o and removed_count_o for one cycle
//   while done_o is high. the receiver cannot stall, so a result is never
//   held back.
//   the entries live in one ram (address, port, age), valid bits in flops.
//   each request walks the whole ram, one entry per cycle through the read
//   port, with the read-modify-write of aging on the write port in the
//   cycle after each read. a request runs through the walk, the drain, the
//   finish step and the result step; busy_o stays high until the finish
//   step is over, so no new request is taken before then. the next request
//   may be accepted in the cycle that done_o is high.
//   age_timeout is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while idle, the block itself does not enforce this.
//   reset empties the table at once (valid bits cleared) and sets the
//   timeout to 30; there is no clearing pass.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging #(
  parameter int unsigned TableEntries = mlt_pkg::TableEntriesDef,
  parameter int unsigned PortBits     = mlt_pkg::PortBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [mlt_pkg::OpW-1:0]     operation_i,
  input  logic [mlt_pkg::MacW-1:0]    mac_address_i,
  input  logic [mlt_pkg::PortW-1:0]   port_in_i,
  input  logic                        cfg_we_i,
  input  logic [mlt_pkg::AgeW-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [mlt_pkg::PortW-1:0]   port_out_o,
  output logic                        table_full_o,
  output logic [mlt_pkg::CountW-1:0]  removed_count_o
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned EntW = mlt_pkg::MacW + PortBits + mlt_pkg::AgeW;
  localparam logic [CntW-1:0] LastCnt = CntW'(TableEntries);

  // request registers
  mlt_pkg::state_e              state_q, state_d;
  mlt_pkg::op_e                 op_q;
  logic [mlt_pkg::MacW-1:0]     mac_q;
  logic [PortBits-1:0]          port_q;
  logic [mlt_pkg::AgeW-1:0]     timeout_q;

  // scan pipeline: issue counter and the entry whose data is on the ram output
  logic [CntW-1:0]              issue_q, issue_d;
  logic                         chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]              chk_idx_q, chk_idx_d;

  // scan results
  logic                         found_q, found_d;
  logic [IdxW-1:0]              found_idx_q, found_idx_d;
  logic [PortBits-1:0]          found_port_q, found_port_d;
  logic                         free_q, free_d;
  logic [IdxW-1:0]              free_idx_q, free_idx_d;
  logic [mlt_pkg::CountW-1:0]   removed_q, removed_d;

  logic [TableEntries-1:0]      valid_q, valid_d;

  // result registers
  logic                         done_q;
  logic                         hit_q;
  logic [mlt_pkg::PortW-1:0]    port_out_q;
  logic                         full_q;
  logic [mlt_pkg::CountW-1:0]   count_q;

  // ram ports
  logic                         ram_we, ram_re;
  logic [IdxW-1:0]              ram_waddr, ram_raddr;
  logic [EntW-1:0]              ram_wdata, ram_rdata;

  logic [mlt_pkg::MacW-1:0]     rd_mac;
  logic [PortBits-1:0]          rd_port;
  logic [mlt_pkg::AgeW-1:0]     rd_age, new_age;
  logic                         rd_valid;
  logic [7:0]                   port_in_ext, found_port_ext;
  logic [PortBits-1:0]          port_in_store;
  logic                         accept;

  assign accept = start_i && (state_q == mlt_pkg::ST_IDLE);
  assign busy_o = (state_q != mlt_pkg::ST_IDLE);

  assign port_in_ext   = 8'(port_in_i);
  assign port_in_store = port_in_ext[PortBits-1:0];
  assign found_port_ext = 8'(found_port_q);

  assign {rd_mac, rd_port, rd_age} = ram_rdata;
  assign rd_valid = chk_vld_q && valid_q[chk_idx_q];
  assign new_age  = (rd_age == mlt_pkg::AgeMax) ? rd_age : rd_age + 1'b1;

  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_port_d = found_port_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    removed_d    = removed_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = {rd_mac, rd_port, new_age};
    ram_re       = 1'b0;
    ram_raddr    = issue_q[IdxW-1:0];

    case (state_q)
      mlt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d   = mlt_pkg::ST_SCAN;
          issue_d   = '0;
          found_d   = 1'b0;
          free_d    = 1'b0;
          removed_d = '0;
        end
      end
      mlt_pkg::ST_SCAN: begin
        // issue the next read
        if (issue_q != LastCnt) begin
          ram_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + 1'b1;
        end
        // check the entry read last cycle
        if (chk_vld_q) begin
          if (rd_valid && (rd_mac == mac_q) && !found_q) begin
            found_d      = 1'b1;
            found_idx_d  = chk_idx_q;
            found_port_d = rd_port;
          end
          if (!valid_q[chk_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if ((op_q == mlt_pkg::OP_TICK) && rd_valid) begin
            ram_we = 1'b1;
            if (new_age > timeout_q) begin
              valid_d[chk_idx_q] = 1'b0;
              if (removed_q != mlt_pkg::CountMax) begin
                removed_d = removed_q + 1'b1;
              end
            end
          end
        end
        if ((issue_q == LastCnt) && !chk_vld_q) begin
          state_d = mlt_pkg::ST_FINISH;
        end
      end
      mlt_pkg::ST_FINISH: begin
        // learn: refresh in place, else take the lowest free entry
        ram_wdata = {mac_q, port_q, {mlt_pkg::AgeW{1'b0}}};
        if (op_q == mlt_pkg::OP_LEARN) begin
          if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = found_idx_q;
          end else if (free_q) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
          end
        end
        state_d = mlt_pkg::ST_IDLE;
      end
      default: begin
        state_d = mlt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mlt_pkg::ST_IDLE;
      timeout_q <= mlt_pkg::AgeTimeoutRst;
      valid_q   <= '0;
      chk_vld_q <= 1'b0;
      issue_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      chk_vld_q <= chk_vld_d;
      issue_q   <= issue_d;
      done_q    <= (state_q == mlt_pkg::ST_FINISH);
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    found_q      <= found_d;
    found_idx_q  <= found_idx_d;
    found_port_q <= found_port_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    removed_q    <= removed_d;
    if (accept) begin
      op_q   <= mlt_pkg::op_e'(operation_i);
      mac_q  <= mac_address_i;
      port_q <= port_in_store;
    end
    if (state_q == mlt_pkg::ST_FINISH) begin
      hit_q      <= (op_q == mlt_pkg::OP_LOOKUP) && found_q;
      port_out_q <= ((op_q == mlt_pkg::OP_LOOKUP) && found_q) ?
                    found_port_ext[mlt_pkg::PortW-1:0] : '0;
      full_q     <= (op_q == mlt_pkg::OP_LEARN) && !found_q && !free_q;
      count_q    <= (op_q == mlt_pkg::OP_TICK) ? removed_q : '0;
    end
  end

  mlt_ram #(
    .Width (EntW),
    .Depth (TableEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign port_out_o      = port_out_q;
  assign table_full_o    = full_q;
  assign removed_count_o = count_q;

  // a result only follows the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == mlt_pkg::ST_FINISH))
    else $error("result without finish step");

  // ram writes happen only while scanning or finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == mlt_pkg::ST_SCAN || state_q == mlt_pkg::ST_FINISH))
    else $error("ram write outside of a request");

  // full and hit never report together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(full_q && hit_q))
    else $error("hit and full on one result");

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted request did not start");

  // a scan always ends with the check pipeline drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlt_pkg::ST_FINISH) |-> !chk_vld_q)
    else $error("finish step with pending check");

endmodule
